// ===== src/tpds_pkg.sv =====
// Types and constants shared by the trie prefix search block.
// No dependencies.
`timescale 1ns / 1ps
package tpds_pkg;

   localparam int unsigned FULL_COVER_DICT = 2;
   localparam int unsigned NUM_DICTS       = 3;
   localparam int unsigned IDX_CLAMP       = 8191;
   localparam int unsigned SUM_W           = 17;

   typedef enum logic [1:0] {
      OP_NODE_WR = 2'd0,
      OP_HDR_WR  = 2'd1,
      OP_SEARCH  = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic {
      KIND_MATCH  = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [11:0] address;
      logic [1:0]  dict_select;
      logic [15:0] code;
      logic        last_sibling;
      logic [11:0] next_offset;
      logic [19:0] info_start;
      logic [7:0]  info_len;
      logic [12:0] item_count;
      logic [11:0] node_base;
      logic        word_first;
      logic        word_last;
   } req_item_type;

   typedef struct packed {
      req_item_type item;
      logic         grp_ok;
   } q_entry_type;

   typedef struct packed {
      logic [15:0] code;
      logic        last;
      logic [11:0] next;
      logic [19:0] info_start;
      logic [7:0]  info_len;
   } node_type;

   typedef struct packed {
      logic [12:0] count;
      logic [11:0] base;
   } hdr_type;

endpackage

// ===== src/tpds_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
// Depends on nothing.
`timescale 1ns / 1ps
interface tpds_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [11:0] address;
   logic [1:0]  dict_select;
   logic [15:0] code;
   logic        last_sibling;
   logic [11:0] next_offset;
   logic [19:0] info_start;
   logic [7:0]  info_len;
   logic [12:0] item_count;
   logic [11:0] node_base;
   logic        word_first;
   logic        word_last;
   modport source (output valid, op, address, dict_select, code, last_sibling, next_offset,
                   info_start, info_len, item_count, node_base, word_first, word_last,
                   input ready);
   modport sink (input valid, op, address, dict_select, code, last_sibling, next_offset,
                 info_start, info_len, item_count, node_base, word_first, word_last,
                 output ready);
endinterface

interface tpds_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  match_length;
   logic [19:0] match_info_start;
   logic [7:0]  match_info_len;
   logic        found;
   logic        last_of_run;
   modport source (output valid, kind, match_length, match_info_start, match_info_len,
                   found, last_of_run, input ready);
   modport sink (input valid, kind, match_length, match_info_start, match_info_len,
                 found, last_of_run, output ready);
endinterface

// ===== src/tpds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tpds_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/tpds_front.sv =====
// Front stage: takes request transactions, classifies group validity, registers them.
// Depends on tpds_pkg and tpds_if.
`timescale 1ns / 1ps
module tpds_front #(
   parameter int unsigned GROUPS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   tpds_req_if.sink              req_ch,
   output logic                  ent_valid,
   output tpds_pkg::q_entry_type ent,
   input  logic                  ent_ready
);
   import tpds_pkg::*;

   logic        valid_ff, valid_in;
   q_entry_type ent_ff;
   logic        take;

   assign req_ch.ready = !valid_ff || ent_ready;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (ent_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         ent_ff.item.op           <= req_ch.op;
         ent_ff.item.address      <= req_ch.address;
         ent_ff.item.dict_select  <= req_ch.dict_select;
         ent_ff.item.code         <= req_ch.code;
         ent_ff.item.last_sibling <= req_ch.last_sibling;
         ent_ff.item.next_offset  <= req_ch.next_offset;
         ent_ff.item.info_start   <= req_ch.info_start;
         ent_ff.item.info_len     <= req_ch.info_len;
         ent_ff.item.item_count   <= req_ch.item_count;
         ent_ff.item.node_base    <= req_ch.node_base;
         ent_ff.item.word_first   <= req_ch.word_first;
         ent_ff.item.word_last    <= req_ch.word_last;
         ent_ff.grp_ok            <= (req_ch.dict_select < 2'(NUM_DICTS)) &&
                                     ({1'b0, req_ch.address} < 13'(GROUPS));
      end
   end

   assign ent_valid = valid_ff;
   assign ent       = ent_ff;
endmodule

// ===== src/tpds_queue.sv =====
// Short FIFO of classified transactions between front and back.
// Depends on tpds_pkg.
`timescale 1ns / 1ps
module tpds_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  tpds_pkg::q_entry_type push_ent,
   output logic                  push_ready,
   output logic                  pop_valid,
   output tpds_pkg::q_entry_type pop_ent,
   input  logic                  pop_ready
);
   import tpds_pkg::*;

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PW    = $clog2(DEPTH);

   q_entry_type   slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          push, pop;

   assign push_ready = count_ff != (PW+1)'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_ent    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_ent;
      end
   end
endmodule

// ===== src/tpds_back.sv =====
// Back stage: executes table writes and walks the trie per search transaction.
// Depends on tpds_pkg, tpds_if and tpds_ram.
`timescale 1ns / 1ps
module tpds_back #(
   parameter int unsigned NODE_DEPTH = 4096,
   parameter int unsigned GROUPS     = 64,
   parameter int unsigned MAX_CHARS  = 255
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ent_valid,
   input  tpds_pkg::q_entry_type ent,
   output logic                  ent_ready,
   tpds_rsp_if.source            rsp_ch
);
   import tpds_pkg::*;

   localparam int unsigned HDR_DEPTH = NUM_DICTS * GROUPS;
   localparam int unsigned HW        = $clog2(HDR_DEPTH);
   localparam int unsigned NW        = $clog2(NODE_DEPTH);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_HDR   = 8'b0000_0100,
      S_MOD   = 8'b0000_1000,
      S_SCAN  = 8'b0001_0000,
      S_NODE  = 8'b0010_0000,
      S_MATCH = 8'b0100_0000,
      S_STAT  = 8'b1000_0000
   } state_type;

   state_type       state_ff, state_in;
   logic [HW-1:0]   clr_ff, clr_in;
   logic [HW-1:0]   act_ff, act_in;
   logic [1:0]      dict_ff, dict_in;
   logic [12:0]     cur_ff, cur_in;
   logic [12:0]     rel_ff, rel_in;
   logic [12:0]     cnt_ff, cnt_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [NW-1:0]   naddr_ff, naddr_in;
   logic [7:0]      cc_ff, cc_in, mc_ff, mc_in, lm_ff, lm_in;
   logic            stop_ff, stop_in;
   logic            first_ff, first_in, last_ff, last_in;
   logic [15:0]     code_ff, code_in;
   logic [19:0]     mis_ff, mis_in;
   logic [7:0]      mil_ff, mil_in;

   logic            rv_ff, rv_in;
   logic            rkind_ff, rkind_in, rfound_ff, rfound_in, rlast_ff, rlast_in;
   logic [7:0]      rlen_ff, rlen_in, rilen_ff, rilen_in;
   logic [19:0]     ristart_ff, ristart_in;

   logic            out_free;
   logic            hdr_we, node_we;
   logic [HW-1:0]   hdr_waddr, hdr_raddr, new_grp;
   hdr_type         hdr_wdata, hdr_rd;
   node_type        node_wdata, node_rd;
   logic [7:0]      cc_base;
   logic [SUM_W-1:0] nsum;
   logic            hit_info;

   tpds_ram #(.WIDTH($bits(hdr_type)), .DEPTH(HDR_DEPTH)) u_hdr_ram (
      .clock   (clock),
      .wr_en   (hdr_we),
      .wr_addr (hdr_waddr),
      .wr_data (hdr_wdata),
      .rd_addr (hdr_raddr),
      .rd_data (hdr_rd)
   );

   tpds_ram #(.WIDTH($bits(node_type)), .DEPTH(NODE_DEPTH)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (NW'(ent.item.address)),
      .wr_data (node_wdata),
      .rd_addr (naddr_ff),
      .rd_data (node_rd)
   );

   assign out_free  = !rv_ff || rsp_ch.ready;
   assign ent_ready = state_ff == S_IDLE;
   assign new_grp   = HW'(ent.item.dict_select) * HW'(GROUPS) + HW'(ent.item.address);
   assign hdr_raddr = (state_ff == S_IDLE && ent.item.word_first) ?
                      (ent.grp_ok ? new_grp : '0) : act_ff;
   assign node_we   = state_ff == S_IDLE && ent_valid && ent.item.op == OP_NODE_WR;
   assign node_wdata = '{code: ent.item.code, last: ent.item.last_sibling,
                         next: ent.item.next_offset, info_start: ent.item.info_start,
                         info_len: ent.item.info_len};
   assign hit_info  = node_rd.info_start != '0 || node_rd.info_len != '0;
   assign nsum      = SUM_W'(rel_ff) + SUM_W'(node_rd.next);

   always_comb begin
      hdr_we    = 1'b0;
      hdr_waddr = new_grp;
      hdr_wdata = '{count: ent.item.item_count, base: ent.item.node_base};
      if (state_ff == S_CLEAR) begin
         hdr_we    = 1'b1;
         hdr_waddr = clr_ff;
         hdr_wdata = '0;
      end else if (state_ff == S_IDLE && ent_valid && ent.item.op == OP_HDR_WR) begin
         hdr_we = ent.grp_ok;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      act_in   = act_ff;
      dict_in  = dict_ff;
      cur_in   = cur_ff;
      rel_in   = rel_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      naddr_in = naddr_ff;
      cc_in    = cc_ff;
      mc_in    = mc_ff;
      lm_in    = lm_ff;
      stop_in  = stop_ff;
      first_in = first_ff;
      last_in  = last_ff;
      code_in  = code_ff;
      mis_in   = mis_ff;
      mil_in   = mil_ff;
      rv_in      = rv_ff && !rsp_ch.ready;
      rkind_in   = rkind_ff;
      rlen_in    = rlen_ff;
      ristart_in = ristart_ff;
      rilen_in   = rilen_ff;
      rfound_in  = rfound_ff;
      rlast_in   = rlast_ff;
      cc_base    = cc_ff;

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == HW'(HDR_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (ent_valid && ent.item.op == OP_SEARCH) begin
               first_in = ent.item.word_first;
               last_in  = ent.item.word_last;
               code_in  = ent.item.code;
               if (ent.item.word_first) begin
                  cc_base = '0;
                  cur_in  = '0;
                  mc_in   = '0;
                  lm_in   = '0;
                  stop_in = !ent.grp_ok;
                  act_in  = ent.grp_ok ? new_grp : '0;
                  dict_in = ent.grp_ok ? ent.item.dict_select : 2'd0;
               end
               cc_in    = (cc_base < 8'(MAX_CHARS)) ? cc_base + 8'd1 : cc_base;
               state_in = S_HDR;
            end
         end
         S_HDR: begin
            cnt_in = hdr_rd.count;
            sum_in = SUM_W'(hdr_rd.base) + SUM_W'(cur_ff);
            rel_in = cur_ff;
            if (stop_ff || (first_ff && hdr_rd.count == '0)) begin
               stop_in  = 1'b1;
               state_in = last_ff ? S_STAT : S_IDLE;
            end else begin
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (sum_ff >= SUM_W'(NODE_DEPTH)) begin
               sum_in = sum_ff - SUM_W'(NODE_DEPTH);
            end else begin
               naddr_in = NW'(sum_ff);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rel_ff < cnt_ff) begin
               state_in = S_NODE;
            end else begin
               stop_in  = 1'b1;
               state_in = last_ff ? S_STAT : S_IDLE;
            end
         end
         S_NODE: begin
            if (node_rd.code == code_ff) begin
               cur_in = rel_ff;
               mis_in = node_rd.info_start;
               mil_in = node_rd.info_len;
               if (hit_info) begin
                  mc_in = (mc_ff != 8'hFF) ? mc_ff + 8'd1 : mc_ff;
                  lm_in = cc_ff;
               end
               if (!last_ff) begin
                  if (node_rd.next != '0) begin
                     cur_in = (nsum > SUM_W'(IDX_CLAMP)) ? 13'(IDX_CLAMP) : 13'(nsum);
                  end else begin
                     stop_in = 1'b1;
                  end
               end
               state_in = hit_info ? S_MATCH : (last_ff ? S_STAT : S_IDLE);
            end else if (node_rd.last) begin
               stop_in  = 1'b1;
               state_in = last_ff ? S_STAT : S_IDLE;
            end else begin
               rel_in   = rel_ff + 13'd1;
               naddr_in = (naddr_ff == NW'(NODE_DEPTH - 1)) ? '0 : naddr_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_MATCH: begin
            if (out_free) begin
               rv_in      = 1'b1;
               rkind_in   = KIND_MATCH;
               rlen_in    = cc_ff;
               ristart_in = mis_ff;
               rilen_in   = mil_ff;
               rfound_in  = 1'b0;
               rlast_in   = !last_ff;
               state_in   = last_ff ? S_STAT : S_IDLE;
            end
         end
         S_STAT: begin
            if (out_free) begin
               rv_in      = 1'b1;
               rkind_in   = KIND_STATUS;
               rlen_in    = lm_ff;
               ristart_in = '0;
               rilen_in   = '0;
               rfound_in  = mc_ff != '0 &&
                            !(dict_ff == 2'(FULL_COVER_DICT) && lm_ff < cc_ff);
               rlast_in   = 1'b1;
               stop_in    = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         act_ff   <= '0;
         dict_ff  <= '0;
         cur_ff   <= '0;
         cc_ff    <= '0;
         mc_ff    <= '0;
         lm_ff    <= '0;
         stop_ff  <= 1'b0;
         first_ff <= 1'b0;
         last_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         act_ff   <= act_in;
         dict_ff  <= dict_in;
         cur_ff   <= cur_in;
         cc_ff    <= cc_in;
         mc_ff    <= mc_in;
         lm_ff    <= lm_in;
         stop_ff  <= stop_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         rv_ff    <= rv_in;
      end
      rel_ff     <= rel_in;
      cnt_ff     <= cnt_in;
      sum_ff     <= sum_in;
      naddr_ff   <= naddr_in;
      code_ff    <= code_in;
      mis_ff     <= mis_in;
      mil_ff     <= mil_in;
      rkind_ff   <= rkind_in;
      rlen_ff    <= rlen_in;
      ristart_ff <= ristart_in;
      rilen_ff   <= rilen_in;
      rfound_ff  <= rfound_in;
      rlast_ff   <= rlast_in;
   end

   assign rsp_ch.valid            = rv_ff;
   assign rsp_ch.kind             = rkind_ff;
   assign rsp_ch.match_length     = rlen_ff;
   assign rsp_ch.match_info_start = ristart_ff;
   assign rsp_ch.match_info_len   = rilen_ff;
   assign rsp_ch.found            = rfound_ff;
   assign rsp_ch.last_of_run      = rlast_ff;
endmodule

// ===== src/trie_prefix_dictionary_search.sv =====
// Top level of the trie common-prefix search block: front, queue and back.
// Depends on tpds_pkg, tpds_if, tpds_front, tpds_queue and tpds_back.
//
//   channel   direction  contents
//   req_ch    in         node write, group header write, search character
//   rsp_ch    out        prefix match or end-of-word status, up to two per character
//
// Table writes are done in the back stage's idle state. A search character reads its
// group header (S_HDR), wraps base + index into the node table (S_MOD), scans siblings
// through the node RAM's registered read (S_SCAN, S_NODE) and emits results (S_MATCH,
// S_STAT). After reset the back stage clears all 3 * GROUPS header entries before it
// takes transactions. The front stage and a four-entry queue keep taking requests,
// until the queue is full, while the back stage walks or waits on a stalled response.
`timescale 1ns / 1ps
module trie_prefix_dictionary_search #(
   parameter int unsigned NODE_DEPTH = 4096,
   parameter int unsigned GROUPS     = 64,
   parameter int unsigned MAX_CHARS  = 255
) (
   input  logic       clock,
   input  logic       reset,
   tpds_req_if.sink   req_ch,
   tpds_rsp_if.source rsp_ch
);
   import tpds_pkg::*;

   logic        f_valid, f_ready, b_valid, b_ready;
   q_entry_type f_ent, b_ent;

   tpds_front #(.GROUPS(GROUPS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .ent_valid (f_valid),
      .ent       (f_ent),
      .ent_ready (f_ready)
   );

   tpds_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ent   (f_ent),
      .push_ready (f_ready),
      .pop_valid  (b_valid),
      .pop_ent    (b_ent),
      .pop_ready  (b_ready)
   );

   tpds_back #(
      .NODE_DEPTH (NODE_DEPTH),
      .GROUPS     (GROUPS),
      .MAX_CHARS  (MAX_CHARS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .ent_valid (b_valid),
      .ent       (b_ent),
      .ent_ready (b_ready),
      .rsp_ch    (rsp_ch)
   );
endmodule

// ===== tb/sv/trie_prefix_dictionary_search_checker.sv =====
// Response checker for the trie common-prefix search block: watches both channels,
// predicts every response from its own copy of the tables and compares in order.
// Depends on tpds_pkg and tpds_if.
`timescale 1ns / 1ps
module trie_prefix_dictionary_search_checker #(
   parameter int unsigned GROUPS    = 64,
   parameter int unsigned MAX_CHARS = 255
) (
   input  logic clock,
   input  logic reset,
   tpds_req_if  req,
   tpds_rsp_if  rsp,
   output int   mismatches,
   output int   pending
);
   import tpds_pkg::*;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  length;
      logic [19:0] info_start;
      logic [7:0]  info_len;
      logic        found;
      logic        last_of_run;
   } search_result_type;

   node_type          trie_nodes [4096];
   hdr_type           group_hdrs [NUM_DICTS * GROUPS];
   int unsigned       walk_index;
   int unsigned       chars_seen;
   int unsigned       matches_seen;
   int unsigned       longest_len;
   bit                walk_stopped;
   int unsigned       word_group;
   search_result_type expected_results [$];

   task automatic report(input string field, input int unsigned got, input int unsigned want);
      $display("%0t ns: %s got 0x%0h, want 0x%0h", $time, field, got, want);
      mismatches++;
   endtask

   task automatic push_result(input kind_type k, input int unsigned len, input logic [19:0] is,
                              input logic [7:0] il, input bit fnd, input bit lst);
      search_result_type r;
      r.kind        = k;
      r.length      = len[7:0];
      r.info_start  = is;
      r.info_len    = il;
      r.found       = fnd;
      r.last_of_run = lst;
      expected_results.push_back(r);
   endtask

   task automatic walk_trie(input req_item_type it);
      hdr_type     h;
      node_type    nd;
      int unsigned rel;
      int unsigned pos;
      int unsigned step;
      bit          hit;
      bit          fnd;
      case (op_type'(it.op))
         OP_NODE_WR: begin
            trie_nodes[it.address].code       = it.code;
            trie_nodes[it.address].last       = it.last_sibling;
            trie_nodes[it.address].next       = it.next_offset;
            trie_nodes[it.address].info_start = it.info_start;
            trie_nodes[it.address].info_len   = it.info_len;
         end
         OP_HDR_WR: begin
            if (it.dict_select < NUM_DICTS && it.address < GROUPS) begin
               group_hdrs[it.dict_select * GROUPS + it.address].count = it.item_count;
               group_hdrs[it.dict_select * GROUPS + it.address].base  = it.node_base;
            end
         end
         OP_SEARCH: begin
            if (it.word_first) begin
               walk_index   = 0;
               chars_seen   = 0;
               matches_seen = 0;
               longest_len  = 0;
               walk_stopped = 0;
               if (it.dict_select < NUM_DICTS && it.address < GROUPS) begin
                  word_group = it.dict_select * GROUPS + it.address;
                  if (group_hdrs[word_group].count == 0) walk_stopped = 1;
               end else begin
                  word_group   = 0;
                  walk_stopped = 1;
               end
            end
            if (chars_seen < MAX_CHARS) chars_seen++;
            pos = chars_seen;
            if (!walk_stopped) begin
               h   = group_hdrs[word_group % (NUM_DICTS * GROUPS)];
               rel = walk_index;
               hit = 0;
               while (rel < h.count) begin
                  nd = trie_nodes[(h.base + rel) % 4096];
                  if (nd.code == it.code) begin
                     hit = 1;
                     break;
                  end
                  if (nd.last) break;
                  rel++;
               end
               if (!hit) begin
                  walk_stopped = 1;
               end else begin
                  walk_index = rel;
                  if (nd.info_start != 0 || nd.info_len != 0) begin
                     push_result(KIND_MATCH, pos, nd.info_start, nd.info_len, 0, !it.word_last);
                     if (matches_seen < 255) matches_seen++;
                     longest_len = pos;
                  end
                  if (!it.word_last) begin
                     if (nd.next != 0) begin
                        step       = rel + nd.next;
                        walk_index = step > IDX_CLAMP ? IDX_CLAMP : step;
                     end else begin
                        walk_stopped = 1;
                     end
                  end
               end
            end
            if (it.word_last) begin
               fnd = matches_seen != 0;
               if (fnd && word_group / GROUPS == FULL_COVER_DICT && longest_len < chars_seen)
                  fnd = 0;
               push_result(KIND_STATUS, longest_len, 0, 0, fnd, 1);
               walk_stopped = 1;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      req_item_type      it;
      search_result_type want;
      if (reset) begin
         foreach (group_hdrs[i]) group_hdrs[i] = '0;
         walk_index   = 0;
         chars_seen   = 0;
         matches_seen = 0;
         longest_len  = 0;
         walk_stopped = 0;
         word_group   = 0;
         expected_results.delete();
         mismatches   = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               report("unexpected response kind", rsp.kind, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp.kind !== want.kind) report("kind", rsp.kind, want.kind);
               if (rsp.match_length !== want.length)
                  report("match_length", rsp.match_length, want.length);
               if (rsp.match_info_start !== want.info_start)
                  report("match_info_start", rsp.match_info_start, want.info_start);
               if (rsp.match_info_len !== want.info_len)
                  report("match_info_len", rsp.match_info_len, want.info_len);
               if (rsp.found !== want.found) report("found", rsp.found, want.found);
               if (rsp.last_of_run !== want.last_of_run)
                  report("last_of_run", rsp.last_of_run, want.last_of_run);
            end
         end
         if (req.valid && req.ready) begin
            it.op           = req.op;
            it.address      = req.address;
            it.dict_select  = req.dict_select;
            it.code         = req.code;
            it.last_sibling = req.last_sibling;
            it.next_offset  = req.next_offset;
            it.info_start   = req.info_start;
            it.info_len     = req.info_len;
            it.item_count   = req.item_count;
            it.node_base    = req.node_base;
            it.word_first   = req.word_first;
            it.word_last    = req.word_last;
            walk_trie(it);
         end
      end
      pending = expected_results.size();
   end

endmodule

// ===== tb/sv/trie_prefix_dictionary_search_tb.sv =====
// Testbench top for the trie common-prefix search block: clock, reset, stimulus
// and verdict. Depends on tpds_pkg, tpds_if, the block and its checker.
`timescale 1ns / 1ps
module trie_prefix_dictionary_search_tb;
   import tpds_pkg::*;

   localparam int unsigned GROUPS      = 64;
   localparam int unsigned CYCLE_LIMIT = 1500000;

   logic clock;
   logic reset;
   int   mismatches;
   int   pending;
   int   cycles = 0;
   int   gap_pct;
   int   stall_pct;
   int   hold_len;
   int   hold_cnt;

   bit      written [4096];
   hdr_type shadow_hdr [NUM_DICTS * GROUPS];

   tpds_req_if req_ch ();
   tpds_rsp_if rsp_ch ();

   trie_prefix_dictionary_search dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   trie_prefix_dictionary_search_checker #(.GROUPS(GROUPS)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial clock = 0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // hold off responses for a counted stretch, else stall at random
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt = 0;
         rsp_ch.ready <= 0;
      end else if (hold_cnt < hold_len) begin
         hold_cnt = hold_cnt + 1;
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= ($urandom % 100) >= stall_pct;
      end
   end

   function automatic req_item_type noise_item();
      req_item_type it;
      it = req_item_type'($bits(req_item_type)'({$urandom, $urandom, $urandom, $urandom}));
      return it;
   endfunction

   function automatic logic [15:0] pick_code();
      int r;
      r = $urandom % 16;
      if (r == 0) return 16'($urandom_range(0, 65535));
      if (r == 1) return 16'hFFFF;
      return 16'($urandom % 4);
   endfunction

   function automatic bit group_safe(int d, int g);
      hdr_type h;
      h = shadow_hdr[d * GROUPS + g];
      for (int i = 0; i < h.count; i++)
         if (!written[(h.base + i) % 4096]) return 0;
      return 1;
   endfunction

   task automatic send(input req_item_type it);
      if (($urandom % 100) < gap_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
         while (($urandom % 100) < gap_pct) @(posedge clock);
      end
      req_ch.valid        <= 1;
      req_ch.op           <= it.op;
      req_ch.address      <= it.address;
      req_ch.dict_select  <= it.dict_select;
      req_ch.code         <= it.code;
      req_ch.last_sibling <= it.last_sibling;
      req_ch.next_offset  <= it.next_offset;
      req_ch.info_start   <= it.info_start;
      req_ch.info_len     <= it.info_len;
      req_ch.item_count   <= it.item_count;
      req_ch.node_base    <= it.node_base;
      req_ch.word_first   <= it.word_first;
      req_ch.word_last    <= it.word_last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic node_write(input int addr, input logic [15:0] code, input bit last,
                             input int next, input logic [19:0] istart, input logic [7:0] ilen);
      req_item_type it;
      it              = noise_item();
      it.op           = OP_NODE_WR;
      it.address      = 12'(addr);
      it.code         = code;
      it.last_sibling = last;
      it.next_offset  = 12'(next);
      it.info_start   = istart;
      it.info_len     = ilen;
      written[addr % 4096] = 1;
      send(it);
   endtask

   task automatic header_write(input int d, input int g, input int count, input int base);
      req_item_type it;
      it             = noise_item();
      it.op          = OP_HDR_WR;
      it.dict_select = 2'(d);
      it.address     = 12'(g);
      it.item_count  = 13'(count);
      it.node_base   = 12'(base);
      if (d < NUM_DICTS && g < GROUPS) begin
         shadow_hdr[d * GROUPS + g].count = 13'(count);
         shadow_hdr[d * GROUPS + g].base  = 12'(base);
      end
      send(it);
   endtask

   task automatic search_char(input int d, input int g, input logic [15:0] code,
                              input bit first, input bit last);
      req_item_type it;
      it             = noise_item();
      it.op          = OP_SEARCH;
      it.dict_select = 2'(d);
      it.address     = 12'(g);
      it.code        = code;
      it.word_first  = first;
      it.word_last   = last;
      send(it);
   endtask

   task automatic build_group(input int d, input int g, input int base, input int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom % 4;
         node_write((base + i) % 4096, pick_code(), i == count - 1 || r == 0,
                    ($urandom % 3 == 0) ? 0 : $urandom_range(1, count),
                    r == 1 ? 20'd0 : 20'($urandom_range(0, 1048575)),
                    r == 2 ? 8'd0 : 8'($urandom % 256));
      end
      header_write(d, g, count, base);
   endtask

   task automatic word(input int d, input int g, input int len, input bit with_first);
      for (int i = 0; i < len; i++)
         search_char(d, g, pick_code(), i == 0 && with_first, i == len - 1);
   endtask

   initial begin
      int searched;
      int r;
      int d;
      int g;
      int tries;
      int phase;
      req_item_type it;
      reset        = 1;
      gap_pct      = 0;
      stall_pct    = 0;
      hold_len     = 0;
      searched     = 0;
      phase        = -1;
      req_ch.valid = 0;
      req_ch.op           = OP_NONE;
      req_ch.address      = 0;
      req_ch.dict_select  = 0;
      req_ch.code         = 0;
      req_ch.last_sibling = 0;
      req_ch.next_offset  = 0;
      req_ch.info_start   = 0;
      req_ch.info_len     = 0;
      req_ch.item_count   = 0;
      req_ch.node_base    = 0;
      req_ch.word_first   = 0;
      req_ch.word_last    = 0;
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed: extremes, wrap of the node table, bad headers and bad starts
      node_write(4095, 16'hFFFF, 1, 4095, 20'hFFFFF, 8'hFF);
      node_write(2000, 16'h0000, 0, 0, 20'h00000, 8'h01);
      build_group(0, 0, 0, 8);
      build_group(1, 1, 4090, 10);
      build_group(2, 2, 100, 6);
      header_write(1, 63, 4096, 0);
      header_write(3, 5, 13'h1FFF, 12'hFFF);
      header_write(0, 4095, 13'h1555, 12'hAAA);
      it    = noise_item();
      it.op = OP_NONE;
      send(it);
      word(0, 0, 3, 1);
      word(1, 1, 4, 1);
      word(2, 2, 3, 1);
      word(0, 5, 2, 1);
      word(3, 0, 2, 1);
      word(0, 4095, 2, 1);
      word(0, 0, 2, 0);
      word(2, 2, 300, 1);

      while (searched < 1000) begin
         if (searched / 250 > phase) begin
            phase = searched / 250;
            case (phase)
               0: begin gap_pct = 0;  stall_pct = 0;  end
               1: begin gap_pct = 85; stall_pct = 0;  hold_len = 600; end
               2: begin
                  req_ch.valid <= 0;
                  @(posedge clock);
                  while (pending != 0) @(posedge clock);
                  gap_pct = 0; stall_pct = 85;
               end
               default: begin gap_pct = 10; stall_pct = 10; end
            endcase
         end
         r = $urandom % 100;
         if (r < 8) begin
            build_group($urandom % 3, $urandom % GROUPS, $urandom % 4096, $urandom_range(1, 12));
         end else if (r < 12) begin
            it = noise_item();
            case ($urandom % 3)
               0: it.op = OP_NODE_WR;
               1: begin it.op = OP_HDR_WR; it.dict_select = 3; end
               default: it.op = OP_NONE;
            endcase
            if (it.op == OP_NODE_WR) written[it.address] = 1;
            send(it);
         end else begin
            r = $urandom % 100;
            if (r < 85) begin
               tries = 0;
               do begin
                  d = $urandom % 3;
                  g = $urandom % GROUPS;
                  tries++;
               end while ((shadow_hdr[d * GROUPS + g].count == 0 || !group_safe(d, g))
                          && tries < 40);
               if (tries >= 40) begin d = 0; g = 0; end
            end else if (r < 92) begin
               d = 3;
               g = $urandom % 4096;
            end else begin
               d = $urandom % 3;
               g = $urandom_range(GROUPS, 4095);
            end
            if (d < 3 && g < GROUPS && !group_safe(d, g)) begin d = 0; g = 0; end
            r = $urandom_range(1, 6);
            word(d, g, r, ($urandom % 10) != 0);
            searched += r;
         end
      end
      req_ch.valid <= 0;
      @(posedge clock);

      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
